FILE: rtl/gaussian_blur_3x3_replicate_defines.svh
// Assertion helpers shared by the blur block.
`ifndef GAUSSIAN_BLUR_3X3_REPLICATE_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_REPLICATE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define GB3R_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GB3R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gb3r_pkg.sv
package gb3r_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int WIDTH_RST     = 1024;
	localparam int HEIGHT_RST    = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_WID_W  = 11;
	localparam int CFG_HGT_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// Q0.16 kernel weights, sum is exactly 65536
	localparam logic [23:0] W_CENTER = 24'd21752;
	localparam logic [23:0] W_EDGE   = 24'd8002;
	localparam logic [23:0] W_CORNER = 24'd2944;

	// output queue, power of two
	localparam int OQ_DEPTH = 8;

	typedef struct packed {
		logic       req_type;
		logic [7:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_done;
	} out_word_t;

	// one window row, index 0 is the left column
	typedef logic [2:0][7:0] px3_t;

	// Weighted sum >> 16. The sum never exceeds 255 * 65536, so the upper
	// byte is already clamped.
	function automatic logic [7:0] blur(input px3_t t, input px3_t m, input px3_t b);
		logic [23:0] edges;
		logic [23:0] corners;
		logic [23:0] s;
		edges   = 24'(t[1]) + 24'(b[1]) + 24'(m[0]) + 24'(m[2]);
		corners = 24'(t[0]) + 24'(t[2]) + 24'(b[0]) + 24'(b[2]);
		s = W_CENTER * 24'(m[1]) + W_EDGE * edges + W_CORNER * corners;
		return s[23:16];
	endfunction

endpackage

FILE: rtl/gaussian_blur_3x3_replicate.sv
// channel | direction | handshake             | word
// in      | input     | in_valid / in_ready   | in_data: req_type, pixel_in
// out     | output    | out_valid / out_ready | out_data: pixel_out, frame_done
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input word per clock while in_ready is high. Results pass through the column
// read, then window and kernel, into an 8-entry output queue.
// A pixel at the end of a row can give two results; the out side drains one per
// clock, so in_ready drops only once the queue is near full, which takes
// out_ready held low.
// Reset clears counters, window and queue; the row stores are not cleared,
// every column is written in a frame before it is read, so no clearing pass.
// cfg_ready is always high; a write to the image width or height restarts the frame.
`include "gaussian_blur_3x3_replicate_defines.svh"

module gaussian_blur_3x3_replicate #(
	parameter int MAX_WIDTH = gb3r_pkg::MAX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  gb3r_pkg::in_word_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output gb3r_pkg::out_word_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gb3r_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gb3r_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import gb3r_pkg::*;

	localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RST_W  = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
	localparam int OQ_AW  = $clog2(OQ_DEPTH);
	localparam int OQ_CW  = OQ_AW + 1;

	// column entry of both row stores: row r-2 and row r-1
	typedef struct packed {
		logic [7:0] older;
		logic [7:0] newer;
	} col_pair_t;

	typedef struct packed {
		logic          is_pix;
		logic          is_fl;
		logic          first_col;
		logic          top_old;
		logic          emit_a;
		logic          emit_b;
		logic          f_first;
		logic          f_last;
		logic [7:0]    px;
		logic [AW-1:0] col;
	} s1_ctl_t;

	// configuration, kept in effective form
	logic [AW-1:0]          wlast_q;
	logic [CFG_HGT_W-1:0]   hgt_q;

	logic [CFG_HGT_W-1:0]   row_q;
	logic [AW-1:0]          col_q;
	logic [AW-1:0]          flush_q;

	col_pair_t              mem [MAX_WIDTH];
	col_pair_t              rda_s1;
	col_pair_t              rdb_s1;
	s1_ctl_t                ctl_s1;
	logic                   vld_s1;

	logic [2:0][2:0][7:0]   win_q;
	logic [2:0][2:0][7:0]   win_d;
	col_pair_t              prev_q;

	out_word_t              oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]       oq_wp_q;
	logic [OQ_AW-1:0]       oq_rp_q;
	logic [OQ_CW-1:0]       oq_cnt_q;

	logic                   in_acc;
	logic                   cfg_acc;
	logic                   pop;
	logic                   pix_ok;
	logic                   fl_ok;
	logic [AW-1:0]          addr_a;
	logic [AW-1:0]          addr_b;
	logic                   wr_en;
	col_pair_t              wr_data;
	s1_ctl_t                ctl_d;
	logic [1:0]             n_s1;
	logic [1:0]             n_push;
	out_word_t              d0;
	out_word_t              d1;
	logic [7:0]             blur_a;
	logic [7:0]             blur_b;
	logic [7:0]             blur_f;
	col_pair_t              fl_l;
	px3_t                   fl_t;
	px3_t                   fl_m;
	logic [7:0]             top_px;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_acc    = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	assign pix_ok = (in_data.req_type == REQ_PIXEL) && (row_q < hgt_q);
	assign fl_ok  = (in_data.req_type == REQ_FLUSH) && (row_q >= hgt_q);

	assign addr_a = (in_data.req_type == REQ_FLUSH) ? flush_q : col_q;
	assign addr_b = (flush_q == wlast_q) ? flush_q : flush_q + 1'b1;

	always_comb begin
		ctl_d           = '0;
		ctl_d.is_pix    = pix_ok;
		ctl_d.is_fl     = fl_ok;
		ctl_d.first_col = (col_q == '0);
		ctl_d.top_old   = (row_q >= 16'd2);
		ctl_d.emit_a    = pix_ok && (row_q != '0) && (col_q != '0);
		ctl_d.emit_b    = pix_ok && (row_q != '0) && (col_q == wlast_q);
		ctl_d.f_first   = (flush_q == '0);
		ctl_d.f_last    = (flush_q == wlast_q);
		ctl_d.px        = in_data.pixel_in;
		ctl_d.col       = col_q;
	end

	// configuration and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= AW'(RST_W - 1);
			hgt_q   <= CFG_HGT_W'(HEIGHT_RST);
			row_q   <= '0;
			col_q   <= '0;
			flush_q <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					if (cfg_data[CFG_WID_W-1:0] == '0)
						wlast_q <= '0;
					else if (int'(cfg_data[CFG_WID_W-1:0]) > MAX_WIDTH)
						wlast_q <= AW'(MAX_WIDTH - 1);
					else
						wlast_q <= AW'(int'(cfg_data[CFG_WID_W-1:0]) - 1);
					row_q   <= '0;
					col_q   <= '0;
					flush_q <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					hgt_q   <= (cfg_data == '0) ? CFG_HGT_W'(1) : cfg_data;
					row_q   <= '0;
					col_q   <= '0;
					flush_q <= '0;
				end
				default: ;
			endcase
		end else if (in_acc) begin
			if (pix_ok) begin
				if (col_q == wlast_q) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (fl_ok) begin
				if (flush_q == wlast_q) begin
					row_q   <= '0;
					col_q   <= '0;
					flush_q <= '0;
				end else begin
					flush_q <= flush_q + 1'b1;
				end
			end
		end
	end

	// Row stores: a pixel's store update is written from stage 1, so a read of the
	// same column while that update is pending takes the new entry directly.
	assign wr_en   = vld_s1 & ctl_s1.is_pix;
	assign wr_data = '{older: rda_s1.newer, newer: ctl_s1.px};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[ctl_s1.col] <= wr_data;
		if (in_acc) begin
			rda_s1 <= (wr_en && ctl_s1.col == addr_a) ? wr_data : mem[addr_a];
			rdb_s1 <= (wr_en && ctl_s1.col == addr_b) ? wr_data : mem[addr_b];
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= in_acc;
	end

	// window shift and kernel
	always_comb begin
		top_px = ctl_s1.top_old ? rda_s1.older : rda_s1.newer;
		win_d  = win_q;
		if (ctl_s1.first_col) begin
			for (int k = 0; k < 3; k++) begin
				win_d[0][k] = top_px;
				win_d[1][k] = rda_s1.newer;
				win_d[2][k] = ctl_s1.px;
			end
		end else begin
			for (int r = 0; r < 3; r++) begin
				win_d[r][0] = win_q[r][1];
				win_d[r][1] = win_q[r][2];
			end
			win_d[0][2] = top_px;
			win_d[1][2] = rda_s1.newer;
			win_d[2][2] = ctl_s1.px;
		end
	end

	assign blur_a = blur(win_d[0], win_d[1], win_d[2]);
	// right border: right column repeated
	assign blur_b = blur({win_d[0][2], win_d[0][2], win_d[0][1]},
	                     {win_d[1][2], win_d[1][2], win_d[1][1]},
	                     {win_d[2][2], win_d[2][2], win_d[2][1]});

	// last row: left neighbor is the previous flush's center column
	assign fl_l = ctl_s1.f_first ? rda_s1 : prev_q;
	assign fl_m = {rdb_s1.newer, rda_s1.newer, fl_l.newer};
	assign fl_t = (hgt_q >= 16'd2) ? {rdb_s1.older, rda_s1.older, fl_l.older} : fl_m;
	assign blur_f = blur(fl_t, fl_m, fl_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (vld_s1 && ctl_s1.is_pix)
			win_q <= win_d;
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && ctl_s1.is_fl)
			prev_q <= rda_s1;
	end

	always_comb begin
		d0     = '{pixel_out: blur_a, frame_done: 1'b0};
		d1     = '{pixel_out: blur_b, frame_done: 1'b0};
		n_push = 2'd0;
		if (vld_s1) begin
			if (ctl_s1.is_fl) begin
				d0     = '{pixel_out: blur_f, frame_done: ctl_s1.f_last};
				n_push = 2'd1;
			end else if (ctl_s1.emit_a) begin
				n_push = ctl_s1.emit_b ? 2'd2 : 2'd1;
			end else if (ctl_s1.emit_b) begin
				d0     = '{pixel_out: blur_b, frame_done: 1'b0};
				n_push = 2'd1;
			end
		end
	end

	// results still owed by the word in stage 1
	assign n_s1 = vld_s1 ? n_push : 2'd0;

	// room for the word in stage 1 and for a new one with two results
	assign in_ready = (int'(oq_cnt_q) + int'(n_s1)) <= (OQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			oq_q[oq_wp_q] <= d0;
		if (n_push == 2'd2)
			oq_q[oq_wp_q + 1'b1] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= '0;
			oq_rp_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			oq_wp_q  <= oq_wp_q + OQ_AW'(n_push);
			oq_rp_q  <= oq_rp_q + OQ_AW'(pop);
			oq_cnt_q <= oq_cnt_q + OQ_CW'(n_push) - OQ_CW'(pop);
		end
	end

	assign out_valid = (oq_cnt_q != '0);
	assign out_data  = oq_q[oq_rp_q];

	`GB3R_ASSERT_NOW(a_oq_bound, 1'b1, int'(oq_cnt_q) <= OQ_DEPTH, "output queue overflow")
	`GB3R_ASSERT_NOW(a_col_range, 1'b1, col_q <= wlast_q && flush_q <= wlast_q, "column past row end")
	`GB3R_ASSERT_NOW(a_frame_restart, vld_s1 && ctl_s1.is_fl && ctl_s1.f_last, row_q == '0 && flush_q == '0, "frame end without counter restart")
	`GB3R_ASSERT_NEXT(a_flush_mode, in_acc && fl_ok && !cfg_acc, vld_s1 && ctl_s1.is_fl && !ctl_s1.is_pix, "flush word lost in stage 1")

endmodule
